// File: sv/bitmap_set_clear_range_test_macros.svh
// ---------------------------------------------------------------------------
// Bit map assertion macros
// Concurrent assertion shorthands used by the bit map sequencer. They compile to
// nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BITMAP_SET_CLEAR_RANGE_TEST_MACROS_SVH
`define BITMAP_SET_CLEAR_RANGE_TEST_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off during rst.
`define BSCRT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define BSCRT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BSCRT_ASSERT_IMP(label, ante, cons, msg)
`define BSCRT_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// File: sv/bscrt_pkg.sv
// ---------------------------------------------------------------------------
// Bit map package
// Sizes, codes, types and the decoded request record of the bit map block.
// ---------------------------------------------------------------------------
package bscrt_pkg;

  // Store geometry.
  localparam int unsigned MAP_BITS    = 4096;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned STORE_BYTES = (MAP_BITS + 7) / 8;
  localparam int unsigned ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  // Field widths.
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned SIZE_W = 13;
  localparam int unsigned BIT_W  = 3;
  localparam int unsigned CMP_W  = 17;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [BIT_W-1:0]  bit_idx_t;

  localparam logic [SIZE_W-1:0] MAP_SIZE_RST = SIZE_W'(4096);
  localparam addr_t             LAST_ADDR    = addr_t'(STORE_BYTES - 1);
  localparam byte_t             BYTE_ONES    = 8'hff;
  localparam byte_t             BYTE_ZEROS   = 8'h00;
  localparam byte_t             BYTE_LSB     = 8'h01;
  localparam bit_idx_t          TOP_BIT      = 3'd7;

  // Request codes.
  typedef enum logic [FUNC_W-1:0] {
    FN_SET_BIT   = 3'd0,
    FN_CLR_BIT   = 3'd1,
    FN_SET_RANGE = 3'd2,
    FN_CLR_RANGE = 3'd3,
    FN_TEST_BIT  = 3'd4
  } func_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIRST,
    ST_FILL,
    ST_LAST
  } state_t;

  // Request after position checks and byte/bit split.
  typedef struct packed {
    func_t    op;
    logic     err;
    addr_t    fb;
    addr_t    lb;
    bit_idx_t lo;
    bit_idx_t hi;
  } req_t;

endpackage

// File: sv/bscrt_req_if.sv
// ---------------------------------------------------------------------------
// Bit map request channel
// Valid/ready channel carrying one request beat.
// ---------------------------------------------------------------------------
interface bscrt_req_if;

  logic                          valid;
  logic                          ready;
  logic [bscrt_pkg::FUNC_W-1:0]  func;
  logic [bscrt_pkg::POS_W-1:0]   first_pos;
  logic [bscrt_pkg::POS_W-1:0]   last_pos;

  modport source (output valid, func, first_pos, last_pos, input ready);
  modport sink   (input valid, func, first_pos, last_pos, output ready);

endinterface

// File: sv/bscrt_rsp_if.sv
// ---------------------------------------------------------------------------
// Bit map response channel
// Valid/ready channel carrying one result beat.
// ---------------------------------------------------------------------------
interface bscrt_rsp_if;

  logic valid;
  logic ready;
  logic status;
  logic bit_value;

  modport source (output valid, status, bit_value, input ready);
  modport sink   (input valid, status, bit_value, output ready);

endinterface

// File: sv/bscrt_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered and only
// changes on a read.
// ---------------------------------------------------------------------------
module bscrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/bscrt_ctrl.sv
// ---------------------------------------------------------------------------
// Bit map sequencer
// Runs the clearing pass, the read-modify-write of single bits and the
// byte walk of range fills, and holds the result beat.
// ---------------------------------------------------------------------------
`include "bitmap_set_clear_range_test_macros.svh"

module bscrt_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  bscrt_pkg::req_t         dec,
  bscrt_rsp_if.source             rsp,
  output logic                    mem_we,
  output bscrt_pkg::addr_t        mem_waddr,
  output bscrt_pkg::byte_t        mem_wdata,
  output logic                    mem_re,
  output bscrt_pkg::addr_t        mem_raddr,
  input  bscrt_pkg::byte_t        mem_rdata
);

  bscrt_pkg::state_t state, state_next;
  bscrt_pkg::req_t   cur;
  bscrt_pkg::addr_t  clr_addr, clr_addr_next;
  bscrt_pkg::addr_t  fill_addr, fill_addr_next;

  logic             emit;
  logic             emit_status;
  logic             emit_bit;
  logic             out_free;
  logic             is_set;
  bscrt_pkg::byte_t lo_mask;
  bscrt_pkg::byte_t hi_mask;
  bscrt_pkg::byte_t bit_mask;
  bscrt_pkg::byte_t first_mask;
  bscrt_pkg::byte_t fill_byte;
  bscrt_pkg::byte_t first_wdata;
  bscrt_pkg::byte_t last_wdata;

  // Byte masks for the current request.
  always_comb begin
    is_set   = (cur.op == bscrt_pkg::FN_SET_BIT) || (cur.op == bscrt_pkg::FN_SET_RANGE);
    lo_mask  = bscrt_pkg::BYTE_ONES << cur.lo;
    hi_mask  = bscrt_pkg::BYTE_ONES >> (bscrt_pkg::TOP_BIT - cur.hi);
    bit_mask = bscrt_pkg::BYTE_LSB << cur.lo;
    if ((cur.op == bscrt_pkg::FN_SET_BIT) || (cur.op == bscrt_pkg::FN_CLR_BIT)) begin
      first_mask = bit_mask;
    end else if (cur.fb == cur.lb) begin
      first_mask = lo_mask & hi_mask;
    end else begin
      first_mask = lo_mask;
    end
    fill_byte   = is_set ? bscrt_pkg::BYTE_ONES : bscrt_pkg::BYTE_ZEROS;
    first_wdata = is_set ? (mem_rdata | first_mask) : (mem_rdata & ~first_mask);
    last_wdata  = is_set ? (mem_rdata | hi_mask) : (mem_rdata & ~hi_mask);
    out_free    = !rsp.valid || rsp.ready;
  end

  // Next state, memory accesses and result beat.
  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    fill_addr_next = fill_addr;
    req_ready      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = cur.fb;
    mem_wdata      = first_wdata;
    mem_re         = 1'b0;
    mem_raddr      = dec.fb;
    emit           = 1'b0;
    emit_status    = 1'b0;
    emit_bit       = 1'b0;
    case (state)
      bscrt_pkg::ST_CLEAR: begin
        mem_we        = 1'b1;
        mem_waddr     = clr_addr;
        mem_wdata     = bscrt_pkg::BYTE_ZEROS;
        clr_addr_next = clr_addr + bscrt_pkg::addr_t'(1);
        if (clr_addr == bscrt_pkg::LAST_ADDR) begin
          state_next = bscrt_pkg::ST_IDLE;
        end
      end
      bscrt_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        mem_re    = req_valid;
        if (req_valid) begin
          state_next = bscrt_pkg::ST_FIRST;
        end
      end
      bscrt_pkg::ST_FIRST: begin
        if (out_free) begin
          if (cur.err) begin
            emit        = 1'b1;
            emit_status = 1'b1;
            state_next  = bscrt_pkg::ST_IDLE;
          end else begin
            case (cur.op)
              bscrt_pkg::FN_SET_BIT, bscrt_pkg::FN_CLR_BIT: begin
                mem_we     = 1'b1;
                emit       = 1'b1;
                state_next = bscrt_pkg::ST_IDLE;
              end
              bscrt_pkg::FN_TEST_BIT: begin
                emit       = 1'b1;
                emit_bit   = mem_rdata[cur.lo];
                state_next = bscrt_pkg::ST_IDLE;
              end
              bscrt_pkg::FN_SET_RANGE, bscrt_pkg::FN_CLR_RANGE: begin
                mem_we = 1'b1;
                if (cur.fb == cur.lb) begin
                  emit       = 1'b1;
                  state_next = bscrt_pkg::ST_IDLE;
                end else begin
                  // Fetch the last byte now; the middle bytes never touch it.
                  mem_re         = 1'b1;
                  mem_raddr      = cur.lb;
                  fill_addr_next = cur.fb + bscrt_pkg::addr_t'(1);
                  if (fill_addr_next == cur.lb) begin
                    state_next = bscrt_pkg::ST_LAST;
                  end else begin
                    state_next = bscrt_pkg::ST_FILL;
                  end
                end
              end
              default: begin
                emit        = 1'b1;
                emit_status = 1'b1;
                state_next  = bscrt_pkg::ST_IDLE;
              end
            endcase
          end
        end
      end
      bscrt_pkg::ST_FILL: begin
        mem_we         = 1'b1;
        mem_waddr      = fill_addr;
        mem_wdata      = fill_byte;
        fill_addr_next = fill_addr + bscrt_pkg::addr_t'(1);
        if (fill_addr_next == cur.lb) begin
          state_next = bscrt_pkg::ST_LAST;
        end
      end
      bscrt_pkg::ST_LAST: begin
        if (out_free) begin
          mem_we     = 1'b1;
          mem_waddr  = cur.lb;
          mem_wdata  = last_wdata;
          emit       = 1'b1;
          state_next = bscrt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bscrt_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bscrt_pkg::ST_CLEAR;
      clr_addr  <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      if (emit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    fill_addr <= fill_addr_next;
    if (req_valid && req_ready) begin
      cur <= dec;
    end
    if (emit) begin
      rsp.status    <= emit_status;
      rsp.bit_value <= emit_bit;
    end
  end

  // Checks on the sequencer.
  `BSCRT_ASSERT_IMP(a_err_no_write, (state == bscrt_pkg::ST_FIRST) && cur.err, !mem_we, "error request wrote the store")
  `BSCRT_ASSERT_IMP(a_fill_inside, state == bscrt_pkg::ST_FILL, (fill_addr > cur.fb) && (fill_addr < cur.lb), "fill byte outside the range")
  `BSCRT_ASSERT_IMP(a_beat_source, $rose(rsp.valid), ($past(state) == bscrt_pkg::ST_FIRST) || ($past(state) == bscrt_pkg::ST_LAST), "result beat from wrong state")
  `BSCRT_ASSERT_NXT(a_accept_first, req_valid && req_ready, state == bscrt_pkg::ST_FIRST, "accepted request did not start")

endmodule

// File: sv/bitmap_set_clear_range_test.sv
// ---------------------------------------------------------------------------
// Bit map with range set and clear
// Top level: size register, position checks, sequencer and byte store.
// ---------------------------------------------------------------------------
// Positions run from 1 to map_size (saturated at 4096) and live in a
// 512 x 8 store with registered read. A single-bit set, clear or test is
// read at acceptance and written or answered in the first-byte state; an
// error is answered from that state. A range over more than one byte writes
// its first byte, then the middle bytes whole and then the last byte (only
// the two end bytes are read). After reset the store is zeroed one byte per
// cycle before the first request beat is taken; size writes are taken at
// any time. A held result beat delays the end of the next request until it is taken.
module bitmap_set_clear_range_test (
  input  logic                           clk,
  input  logic                           rst,
  bscrt_req_if.sink                      req,
  bscrt_rsp_if.source                    rsp,
  input  logic                           cfg_we,
  input  logic [bscrt_pkg::SIZE_W-1:0]   cfg_wdata
);

  logic [bscrt_pkg::SIZE_W-1:0] map_size;
  logic [bscrt_pkg::CMP_W-1:0]  vsize;
  logic [bscrt_pkg::POS_W-1:0]  first_m1;
  logic [bscrt_pkg::POS_W-1:0]  last_m1;
  logic                         first_ok;
  logic                         last_ok;
  bscrt_pkg::req_t              dec;

  logic             mem_we;
  bscrt_pkg::addr_t mem_waddr;
  bscrt_pkg::byte_t mem_wdata;
  logic             mem_re;
  bscrt_pkg::addr_t mem_raddr;
  bscrt_pkg::byte_t mem_rdata;

  // Size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_size <= bscrt_pkg::MAP_SIZE_RST;
    end else if (cfg_we) begin
      map_size <= cfg_wdata;
    end
  end

  // Position checks and split into byte address and bit index.
  always_comb begin
    if (bscrt_pkg::CMP_W'(map_size) > bscrt_pkg::CMP_W'(bscrt_pkg::MAP_BITS)) begin
      vsize = bscrt_pkg::CMP_W'(bscrt_pkg::MAP_BITS);
    end else begin
      vsize = bscrt_pkg::CMP_W'(map_size);
    end
    first_ok = (req.first_pos != '0) && (bscrt_pkg::CMP_W'(req.first_pos) <= vsize);
    last_ok  = (req.last_pos != '0) && (bscrt_pkg::CMP_W'(req.last_pos) <= vsize);
    first_m1 = req.first_pos - bscrt_pkg::POS_W'(1);
    last_m1  = req.last_pos - bscrt_pkg::POS_W'(1);

    dec.op = bscrt_pkg::func_t'(req.func);
    dec.fb = first_m1[bscrt_pkg::ADDR_W+2:3];
    dec.lb = last_m1[bscrt_pkg::ADDR_W+2:3];
    dec.lo = first_m1[2:0];
    dec.hi = last_m1[2:0];
    case (bscrt_pkg::func_t'(req.func))
      bscrt_pkg::FN_SET_BIT, bscrt_pkg::FN_CLR_BIT, bscrt_pkg::FN_TEST_BIT: begin
        dec.err = !first_ok;
      end
      bscrt_pkg::FN_SET_RANGE, bscrt_pkg::FN_CLR_RANGE: begin
        dec.err = !(first_ok && last_ok && (req.first_pos <= req.last_pos));
      end
      default: begin
        dec.err = 1'b1;
      end
    endcase
  end

  // Sequencer.
  bscrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .dec       (dec),
    .rsp       (rsp),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Byte store.
  bscrt_ram #(
    .WIDTH (bscrt_pkg::BYTE_W),
    .DEPTH (bscrt_pkg::STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// Bit map with range set and clear: testbench
// Drives set, clear, test and range requests into the bit map through the
// request channel, keeps a shadow copy of the bit store and the size
// register, and checks every result beat against the shadow's prediction.
// Directed edge cases run first, then random traffic under several sizes.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  import bscrt_pkg::*;

  // Codes that the block does not define, and the status values.
  localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;
  localparam logic              STATUS_OK    = 1'b0;
  localparam logic              STATUS_ERR   = 1'b1;

  // Worst case per request: a full-store fill plus the longest gap and stall,
  // taken several times over, plus the clearing pass after reset.
  localparam int unsigned CYCLE_LIMIT = 4 * 1400 * (STORE_BYTES + 32) + 4 * STORE_BYTES;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  first_pos;
    logic [POS_W-1:0]  last_pos;
  } request_t;

  typedef struct {
    logic status;
    logic bit_value;
  } outcome_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;

  bscrt_req_if req_ch ();
  bscrt_rsp_if rsp_ch ();

  bitmap_set_clear_range_test u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the block's store and size register.
  logic [BYTE_W-1:0] shadow_bytes [STORE_BYTES];
  logic [SIZE_W-1:0] shadow_size;

  outcome_t    awaited_outcomes [$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  int unsigned stall_left  = 0;
  logic [15:0] stall_pattern;

  always #5 clk = ~clk;

  // Positions beyond the store are never valid, whatever the register says.
  function automatic int unsigned valid_limit();
    return (shadow_size > MAP_BITS) ? MAP_BITS : int'(shadow_size);
  endfunction

  function automatic bit position_ok(input int unsigned pos);
    return (pos != 0) && (pos <= valid_limit());
  endfunction

  function automatic void put_bit(input int unsigned pos, input logic val);
    int unsigned idx;
    idx = (pos - 1) / BYTE_W;
    shadow_bytes[idx][(pos - 1) % BYTE_W] = val;
  endfunction

  // Applies one request to the shadow and returns the result it must give.
  function automatic outcome_t predict_outcome(input request_t rq);
    outcome_t    res;
    int unsigned first;
    int unsigned last;
    first         = rq.first_pos;
    last          = rq.last_pos;
    res.status    = STATUS_OK;
    res.bit_value = 1'b0;
    case (rq.func)
      FN_SET_BIT, FN_CLR_BIT: begin
        if (position_ok(first)) put_bit(first, rq.func == FN_SET_BIT);
        else res.status = STATUS_ERR;
      end
      FN_SET_RANGE, FN_CLR_RANGE: begin
        if (position_ok(first) && position_ok(last) && first <= last) begin
          for (int unsigned p = first; p <= last; p++) put_bit(p, rq.func == FN_SET_RANGE);
        end else begin
          res.status = STATUS_ERR;
        end
      end
      FN_TEST_BIT: begin
        if (position_ok(first))
          res.bit_value = shadow_bytes[(first - 1) / BYTE_W][(first - 1) % BYTE_W];
        else
          res.status = STATUS_ERR;
      end
      default: begin
        res.status = STATUS_ERR;
      end
    endcase
    return res;
  endfunction

  // Sends one request beat. Beats go out in bursts with idle gaps between
  // them; valid stays high from one beat of a burst to the next.
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] a,
                              input logic [POS_W-1:0] b);
    request_t rq;
    rq.func      = f;
    rq.first_pos = a;
    rq.last_pos  = b;
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 6) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 10);
    end
    burst_left--;
    req_ch.valid     <= 1'b1;
    req_ch.func      <= f;
    req_ch.first_pos <= a;
    req_ch.last_pos  <= b;
    do @(posedge clk); while (!req_ch.ready);
    awaited_outcomes.push_back(predict_outcome(rq));
  endtask

  // Stops sending and waits until every result beat has come back.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_map_size(input logic [SIZE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    shadow_size = v;
  endtask

  // Mostly well-formed requests inside the valid range, with the rest bad
  // positions, reversed ranges, unused codes and raw random fields.
  task automatic send_random_request(input int unsigned lim);
    logic [FUNC_W-1:0] f;
    logic [POS_W-1:0]  a;
    logic [POS_W-1:0]  b;
    int unsigned       span;
    f = FUNC_W'($urandom_range(FN_SET_BIT, FN_TEST_BIT));
    a = POS_W'($urandom);
    b = POS_W'($urandom);
    if (lim != 0 && $urandom_range(0, 9) < 7) begin
      a = POS_W'($urandom_range(1, lim));
      if (f == FN_SET_RANGE || f == FN_CLR_RANGE) begin
        case ($urandom_range(0, 19))
          0: begin
            a = POS_W'($urandom_range(1, (lim < 8) ? lim : 8));
            span = lim;
          end
          1, 2:    span = $urandom_range(0, 300);
          default: span = $urandom_range(0, 24);
        endcase
        b = POS_W'((a + span > lim) ? lim : a + span);
      end
    end else begin
      case ($urandom_range(0, 5))
        0: f = FUNC_W'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
        1: a = '0;
        2: begin
          a = POS_W'(lim + 1);
          b = POS_W'(lim);
        end
        3: begin
          // Raw random fields; nothing to change.
        end
        4: begin
          f = ($urandom_range(0, 1) == 0) ? FN_SET_RANGE : FN_CLR_RANGE;
          a = POS_W'((lim >= 2) ? $urandom_range(2, lim) : 1);
          b = a - 1'b1;
        end
        default: begin
          f = ($urandom_range(0, 1) == 0) ? FN_SET_RANGE : FN_CLR_RANGE;
          a = POS_W'((lim != 0) ? $urandom_range(1, lim) : 1);
          b = POS_W'(($urandom_range(0, 1) == 0) ? lim : lim + 1);
        end
      endcase
    end
    send_request(f, a, b);
  endtask

  // Single-bit set, clear and test at both ends of the map, bad positions
  // and unused codes, under the reset size.
  task automatic test_single_ops();
    send_request(FN_SET_BIT,   16'd1,     16'd0);
    send_request(FN_TEST_BIT,  16'd1,     16'd0);
    send_request(FN_SET_BIT,   16'd4096,  16'hffff);
    send_request(FN_TEST_BIT,  16'd4096,  16'd0);
    send_request(FN_TEST_BIT,  16'd4095,  16'd0);
    send_request(FN_CLR_BIT,   16'd1,     16'd0);
    send_request(FN_TEST_BIT,  16'd1,     16'd0);
    send_request(FN_TEST_BIT,  16'd0,     16'd0);
    send_request(FN_SET_BIT,   16'd4097,  16'd0);
    send_request(FN_CLR_BIT,   16'hffff,  16'hffff);
    send_request(FN_UNUSED_LO, 16'd5,     16'd9);
    send_request(FN_UNUSED_HI, 16'd5,     16'd9);
  endtask

  // Full-map fills, a fill with whole middle bytes, one-bit and bad ranges.
  task automatic test_range_ops();
    send_request(FN_SET_RANGE, 16'd1,    16'd4096);
    send_request(FN_TEST_BIT,  16'd2048, 16'd0);
    send_request(FN_CLR_RANGE, 16'd9,    16'd4088);
    send_request(FN_TEST_BIT,  16'd9,    16'd0);
    send_request(FN_TEST_BIT,  16'd8,    16'd0);
    send_request(FN_TEST_BIT,  16'd4089, 16'd0);
    send_request(FN_SET_RANGE, 16'd100,  16'd100);
    send_request(FN_SET_RANGE, 16'd100,  16'd99);
    send_request(FN_CLR_RANGE, 16'd0,    16'd10);
    send_request(FN_SET_RANGE, 16'd1,    16'd4097);
    send_request(FN_CLR_RANGE, 16'd1,    16'd4096);
    send_request(FN_TEST_BIT,  16'd4096, 16'd0);
  endtask

  // Random traffic in phases, each under its own size: the reset size, zero,
  // one, the largest field value, values around a byte edge and random ones.
  task automatic test_random_traffic();
    int unsigned sizes  [10];
    int unsigned counts [10];
    int unsigned lim;
    sizes  = '{4096, 0, 1, 8191, 9, 4097, $urandom_range(2, 4095), 8,
               $urandom_range(4096, 8191), 4096};
    counts = '{260, 30, 40, 220, 60, 150, 200, 50, 90, 200};
    foreach (sizes[i]) begin
      write_map_size(SIZE_W'(sizes[i]));
      lim = valid_limit();
      repeat (counts[i]) send_random_request(lim);
      drain_results();
    end
  endtask

  // Receiver: ready follows a rotating pattern that is reloaded now and then,
  // from always ready to one beat in sixteen.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(16, 128);
      case ($urandom_range(0, 3))
        0:       stall_pattern = '1;
        1:       stall_pattern = 16'($urandom);
        2:       stall_pattern = 16'($urandom | $urandom);
        default: stall_pattern = 16'h0001;
      endcase
      stall_pattern[0] = 1'b1;
    end
    stall_left--;
    rsp_ch.ready  <= stall_pattern[0];
    stall_pattern  = {stall_pattern[0], stall_pattern[15:1]};
  end

  // Result check: each accepted result beat against the oldest prediction.
  always @(posedge clk) begin
    outcome_t exp_res;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[bitmap_set_clear_range_test] ERROR");
      $finish;
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_outcomes.size() == 0) begin
        $error("result beat with no request waiting");
        fail_count++;
      end else begin
        exp_res = awaited_outcomes.pop_front();
        if (rsp_ch.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, rsp_ch.status);
          fail_count++;
        end
        if (rsp_ch.bit_value !== exp_res.bit_value) begin
          $error("bit_value: expected %0d, got %0d", exp_res.bit_value, rsp_ch.bit_value);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_ch.valid     = 1'b0;
    req_ch.func      = '0;
    req_ch.first_pos = '0;
    req_ch.last_pos  = '0;
    rsp_ch.ready     = 1'b0;
    stall_pattern    = '1;
    shadow_size      = MAP_SIZE_RST;
    foreach (shadow_bytes[i]) shadow_bytes[i] = BYTE_ZEROS;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_single_ops();
    test_range_ops();
    drain_results();
    test_random_traffic();
    drain_results();

    if (fail_count == 0) begin
      $display("[bitmap_set_clear_range_test] OK");
    end else begin
      $display("[bitmap_set_clear_range_test] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/bscrt_pkg.sv
sv/bscrt_req_if.sv
sv/bscrt_rsp_if.sv
sv/bscrt_ram.sv
sv/bscrt_ctrl.sv
sv/bitmap_set_clear_range_test.sv
tb/tb.sv
